// ===== hw/rtl/acal_pkg.sv =====
// ---------------------------------------------------------------------------
// acal_pkg
// Shared types, constants and the arctangent table for the accelerometer
// calibration and tilt pipeline.
// ---------------------------------------------------------------------------
package acal_pkg;

   localparam int ADC_BITS_DEF     = 10;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int OFF_W      = 11;
   localparam int GAIN_W     = 25;
   localparam int ACC_W      = 16;
   localparam int ANG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_X_OFF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFF  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Z_OFF  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Y_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Z_GAIN = 3'd5;

   localparam logic [OFF_W-1:0]         X_OFF_RST  = 11'd1036;
   localparam logic [OFF_W-1:0]         Y_OFF_RST  = 11'd1031;
   localparam logic [OFF_W-1:0]         Z_OFF_RST  = 11'd1014;
   localparam logic signed [GAIN_W-1:0] X_GAIN_RST = -25'sd1315860;
   localparam logic signed [GAIN_W-1:0] Y_GAIN_RST = -25'sd1284380;
   localparam logic signed [GAIN_W-1:0] Z_GAIN_RST = -25'sd1383689;

   // CORDIC datapath widths: operands are scaled by 256 and grow by about 2.3.
   localparam int CW = 28;
   localparam int ZW = 20;
   localparam logic signed [ZW-1:0]    HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25736;

   localparam int QDEPTH = 4;
   localparam int QCW    = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } accel_type;

   function automatic logic signed [ZW-1:0] atan_q16(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = 20'sd51472;
         1:  v = 20'sd30386;
         2:  v = 20'sd16055;
         3:  v = 20'sd8150;
         4:  v = 20'sd4091;
         5:  v = 20'sd2047;
         6:  v = 20'sd1024;
         7:  v = 20'sd512;
         8:  v = 20'sd256;
         9:  v = 20'sd128;
         10: v = 20'sd64;
         11: v = 20'sd32;
         12: v = 20'sd16;
         13: v = 20'sd8;
         14: v = 20'sd4;
         15: v = 20'sd2;
         16: v = 20'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/acal_front.sv =====
// ---------------------------------------------------------------------------
// acal_front
// Calibration registers and per-axis offset, gain and saturation. Accepts a
// sample only when the queue has room for it and anything still in flight.
// ---------------------------------------------------------------------------
module acal_front import acal_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [ADC_BITS-1:0]   x_raw,
   input  logic [ADC_BITS-1:0]   y_raw,
   input  logic [ADC_BITS-1:0]   z_raw,
   input  logic [QCW-1:0]        q_count,
   output logic                  push,
   output accel_type             push_data
);

   localparam int DW = (ADC_BITS + 2 > OFF_W + 1) ? ADC_BITS + 2 : OFF_W + 1;
   localparam int PW = DW + GAIN_W;
   localparam int SW = PW - 16;
   localparam logic signed [SW-1:0] MAXV = SW'(32767);
   localparam logic signed [SW-1:0] MINV = SW'(-32768);

   logic [OFF_W-1:0]         x_off_ff, y_off_ff, z_off_ff;
   logic signed [GAIN_W-1:0] x_gain_ff, y_gain_ff, z_gain_ff;
   logic signed [PW-1:0]     px_ff, py_ff, pz_ff;
   logic signed [PW-1:0]     px_in, py_in, pz_in;
   logic                     p_valid_ff;
   logic [QCW:0]             used;
   logic                     accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_off_ff  <= X_OFF_RST;
         y_off_ff  <= Y_OFF_RST;
         z_off_ff  <= Z_OFF_RST;
         x_gain_ff <= X_GAIN_RST;
         y_gain_ff <= Y_GAIN_RST;
         z_gain_ff <= Z_GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_X_OFF:  x_off_ff  <= csr_data[OFF_W-1:0];
            REG_Y_OFF:  y_off_ff  <= csr_data[OFF_W-1:0];
            REG_Z_OFF:  z_off_ff  <= csr_data[OFF_W-1:0];
            REG_X_GAIN: x_gain_ff <= $signed(csr_data[GAIN_W-1:0]);
            REG_Y_GAIN: y_gain_ff <= $signed(csr_data[GAIN_W-1:0]);
            REG_Z_GAIN: z_gain_ff <= $signed(csr_data[GAIN_W-1:0]);
            default: ;
         endcase
      end
   end

   function automatic logic signed [PW-1:0] cal_mul(input logic [ADC_BITS-1:0] raw,
                                                  input logic [OFF_W-1:0] off,
                                                  input logic signed [GAIN_W-1:0] gain);
      logic [DW-1:0] d;
      d = {{(DW-ADC_BITS-1){1'b0}}, raw, 1'b0} - {{(DW-OFF_W){1'b0}}, off};
      return PW'($signed(d)) * PW'(gain);
   endfunction

   function automatic logic signed [ACC_W-1:0] sat16(input logic signed [PW-1:0] p);
      logic signed [SW-1:0] s;
      s = p[PW-1:16];
      if (s > MAXV) return 16'sh7FFF;
      if (s < MINV) return 16'sh8000;
      return s[ACC_W-1:0];
   endfunction

   // Room is reserved for the product stage, so a push never meets a full queue.
   assign used     = {1'b0, q_count} + {{QCW{1'b0}}, p_valid_ff};
   assign in_ready = used < (QCW+1)'(QDEPTH);
   assign accept   = in_valid && in_ready;

   assign px_in = cal_mul(x_raw, x_off_ff, x_gain_ff);
   assign py_in = cal_mul(y_raw, y_off_ff, y_gain_ff);
   assign pz_in = cal_mul(z_raw, z_off_ff, z_gain_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
   end

   assign push        = p_valid_ff;
   assign push_data.x = sat16(px_ff);
   assign push_data.y = sat16(py_ff);
   assign push_data.z = sat16(pz_ff);

endmodule

// ===== hw/rtl/acal_queue.sv =====
// ---------------------------------------------------------------------------
// acal_queue
// Small FIFO of calibrated samples between the front and back sections.
// ---------------------------------------------------------------------------
module acal_queue import acal_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  accel_type       push_data,
   input  logic            pop,
   output accel_type       pop_data,
   output logic [QCW-1:0]  count
);

   localparam int PTR_W = $clog2(QDEPTH);

   accel_type          mem [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0]     count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QCW'(push) - QCW'(pop);
      end
   end

   assign pop_data = mem[rd_ptr_ff];
   assign count    = count_ff;

endmodule

// ===== hw/rtl/acal_back.sv =====
// ---------------------------------------------------------------------------
// acal_back
// Pipelined magnitude and tilt section: three CORDIC vectoring lanes and a
// digit-per-stage square root, advancing together under one stall enable.
// ---------------------------------------------------------------------------
module acal_back import acal_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [QCW-1:0]          q_count,
   input  accel_type               q_data,
   output logic                    pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output accel_type               out_acc,
   output logic [ACC_W-1:0]        out_mag,
   output logic signed [ANG_W-1:0] out_xy,
   output logic signed [ANG_W-1:0] out_xz,
   output logic signed [ANG_W-1:0] out_yz
);

   localparam int SQ_STEPS = 16;
   localparam int NS = (CORDIC_STEPS > SQ_STEPS + 1) ? CORDIC_STEPS : SQ_STEPS + 1;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } cordic_type;

   typedef struct packed {
      accel_type             acc;
      cordic_type [2:0]      cd;
      logic [2:0][30:0]      sq;
      logic [31:0]           rem;
      logic [31:0]           root;
   } stage_type;

   stage_type  st_ff [NS+1];
   stage_type  st_in [NS+1];
   logic [NS:0] vld_ff;
   logic        adv;

   logic                    rsp_valid_ff;
   accel_type               rsp_acc_ff;
   logic [ACC_W-1:0]        rsp_mag_ff;
   logic signed [ANG_W-1:0] rsp_xy_ff, rsp_xz_ff, rsp_yz_ff;

   function automatic cordic_type pre_rot(input logic signed [ACC_W-1:0] num,
                                          input logic signed [ACC_W-1:0] den);
      cordic_type c;
      logic signed [CW-1:0] xs, ys;
      xs = CW'(den) <<< 8;
      ys = CW'(num) <<< 8;
      c.zero = (num == '0) && (den == '0);
      c.x = xs;
      c.y = ys;
      c.z = '0;
      // A vector in the left half plane is first turned by a quarter turn.
      if (xs < 0) begin
         if (ys >= 0) begin
            c.x = ys;
            c.y = -xs;
            c.z = HALF_PI_Q16;
         end else begin
            c.x = -ys;
            c.y = xs;
            c.z = -HALF_PI_Q16;
         end
      end
      return c;
   endfunction

   function automatic logic signed [ANG_W-1:0] fin_angle(input cordic_type c);
      logic signed [ZW-1:0]   r;
      logic signed [ZW-4:0]   a;
      r = c.z + ZW'(4);
      a = r[ZW-1:3];
      if (c.zero) return '0;
      if (a > (ZW-3)'(PI_Q13)) return PI_Q13;
      if (a < -(ZW-3)'(PI_Q13)) return -PI_Q13;
      return a[ANG_W-1:0];
   endfunction

   assign adv = !rsp_valid_ff || out_ready;
   assign pop = adv && (q_count != '0);

   always_comb begin
      st_in[0].acc  = q_data;
      st_in[0].cd[0] = pre_rot(q_data.y, q_data.x);
      st_in[0].cd[1] = pre_rot(q_data.z, q_data.x);
      st_in[0].cd[2] = pre_rot(q_data.z, q_data.y);
      st_in[0].sq[0] = 31'($signed(q_data.x) * $signed(q_data.x));
      st_in[0].sq[1] = 31'($signed(q_data.y) * $signed(q_data.y));
      st_in[0].sq[2] = 31'($signed(q_data.z) * $signed(q_data.z));
      st_in[0].rem  = '0;
      st_in[0].root = '0;
   end

   for (genvar k = 1; k <= NS; k++) begin : g_stage
      always_comb begin
         logic signed [CW-1:0] xs, ys;
         logic [31:0]          bitv;
         st_in[k] = st_ff[k-1];
         xs = '0;
         ys = '0;
         bitv = '0;
         if (k - 1 < CORDIC_STEPS) begin
            for (int p = 0; p < 3; p++) begin
               xs = st_ff[k-1].cd[p].x >>> (k - 1);
               ys = st_ff[k-1].cd[p].y >>> (k - 1);
               if (st_ff[k-1].cd[p].y > 0) begin
                  st_in[k].cd[p].x = st_ff[k-1].cd[p].x + ys;
                  st_in[k].cd[p].y = st_ff[k-1].cd[p].y - xs;
                  st_in[k].cd[p].z = st_ff[k-1].cd[p].z + atan_q16(k - 1);
               end else begin
                  st_in[k].cd[p].x = st_ff[k-1].cd[p].x - ys;
                  st_in[k].cd[p].y = st_ff[k-1].cd[p].y + xs;
                  st_in[k].cd[p].z = st_ff[k-1].cd[p].z - atan_q16(k - 1);
               end
            end
         end
         if (k == 1) begin
            st_in[k].rem = 32'(st_ff[k-1].sq[0]) + 32'(st_ff[k-1].sq[1])
                         + 32'(st_ff[k-1].sq[2]);
            st_in[k].root = '0;
         end else if (k - 2 < SQ_STEPS) begin
            bitv = 32'd1 << (30 - 2 * (k - 2));
            if (st_ff[k-1].rem >= st_ff[k-1].root + bitv) begin
               st_in[k].rem  = st_ff[k-1].rem - (st_ff[k-1].root + bitv);
               st_in[k].root = (st_ff[k-1].root >> 1) + bitv;
            end else begin
               st_in[k].root = st_ff[k-1].root >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NS-1:0], pop};
         rsp_valid_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= NS; k++) begin
            st_ff[k] <= st_in[k];
         end
         rsp_acc_ff <= st_ff[NS].acc;
         rsp_mag_ff <= (st_ff[NS].root > 32'd65535) ? 16'hFFFF : st_ff[NS].root[15:0];
         rsp_xy_ff  <= fin_angle(st_ff[NS].cd[0]);
         rsp_xz_ff  <= fin_angle(st_ff[NS].cd[1]);
         rsp_yz_ff  <= fin_angle(st_ff[NS].cd[2]);
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_acc   = rsp_acc_ff;
   assign out_mag   = rsp_mag_ff;
   assign out_xy    = rsp_xy_ff;
   assign out_xz    = rsp_xz_ff;
   assign out_yz    = rsp_yz_ff;

endmodule

// ===== hw/rtl/accel_calibrate_tilt_top.sv =====
// A request transfer passes the product register, the queue, the stage registers
// and the response register; below CORDIC_STEPS 17 the square root sets the depth.
// Throughput: one sample per cycle when rsp_ready does not stall the pipeline.
// A four-entry queue separates calibration from the angle pipeline.
// Reset is synchronous: calibration registers return to defaults, all in-flight
// samples are dropped. No clearing pass is needed.
// ---------------------------------------------------------------------------
// accel_calibrate_tilt_top
// Accelerometer calibration with vector magnitude and three tilt angles.
// ---------------------------------------------------------------------------
module accel_calibrate_tilt_top import acal_pkg::*; #(
   parameter int ADC_BITS     = ADC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ADC_BITS-1:0]     req_x_raw,
   input  logic [ADC_BITS-1:0]     req_y_raw,
   input  logic [ADC_BITS-1:0]     req_z_raw,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [ACC_W-1:0] rsp_x_accel,
   output logic signed [ACC_W-1:0] rsp_y_accel,
   output logic signed [ACC_W-1:0] rsp_z_accel,
   output logic [ACC_W-1:0]        rsp_magnitude,
   output logic signed [ANG_W-1:0] rsp_angle_xy,
   output logic signed [ANG_W-1:0] rsp_angle_xz,
   output logic signed [ANG_W-1:0] rsp_angle_yz
);

   logic           push, pop;
   accel_type      push_data, pop_data, out_acc;
   logic [QCW-1:0] q_count;

   acal_front #(.ADC_BITS(ADC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_raw     (req_x_raw),
      .y_raw     (req_y_raw),
      .z_raw     (req_z_raw),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data)
   );

   acal_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .count     (q_count)
   );

   acal_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_count   (q_count),
      .q_data    (pop_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_acc   (out_acc),
      .out_mag   (rsp_magnitude),
      .out_xy    (rsp_angle_xy),
      .out_xz    (rsp_angle_xz),
      .out_yz    (rsp_angle_yz)
   );

   assign rsp_x_accel = out_acc.x;
   assign rsp_y_accel = out_acc.y;
   assign rsp_z_accel = out_acc.z;

endmodule

// ===== hw/rtl/acal_check.sv =====
// ---------------------------------------------------------------------------
// acal_check
// Port-level checks for the accelerometer tilt block, bound to the top level.
// ---------------------------------------------------------------------------
module acal_check import acal_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [ACC_W-1:0] rsp_x_accel,
   input logic signed [ACC_W-1:0] rsp_y_accel,
   input logic signed [ACC_W-1:0] rsp_z_accel,
   input logic [ACC_W-1:0]        rsp_magnitude,
   input logic signed [ANG_W-1:0] rsp_angle_xy
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_accel)
                                && $stable(rsp_magnitude))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response shown right after reset");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_xy <= PI_Q13) && (rsp_angle_xy >= -PI_Q13))
      else $error("angle beyond pi");

   // A zero vector must give zero length and a zero angle.
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_x_accel == '0 && rsp_y_accel == '0 && rsp_z_accel == '0
      |-> rsp_magnitude == '0 && rsp_angle_xy == '0)
      else $error("zero vector gave nonzero result");

endmodule

bind accel_calibrate_tilt_top acal_check u_acal_check (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_x_accel   (rsp_x_accel),
   .rsp_y_accel   (rsp_y_accel),
   .rsp_z_accel   (rsp_z_accel),
   .rsp_magnitude (rsp_magnitude),
   .rsp_angle_xy  (rsp_angle_xy)
);

// ===== dv/accel_calibrate_tilt_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// accel_calibrate_tilt_checker
// Watches the register port and both channels of the tilt block. It keeps
// its own copy of the calibration registers. For each request transfer it
// works out the expected calibrated triple, the magnitude and the angles.
// It compares every response transfer with the oldest of those.
// ---------------------------------------------------------------------------
module accel_calibrate_tilt_checker import acal_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [ADC_BITS_DEF-1:0] req_x_raw,
   input  logic [ADC_BITS_DEF-1:0] req_y_raw,
   input  logic [ADC_BITS_DEF-1:0] req_z_raw,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [ACC_W-1:0] rsp_x_accel,
   input  logic signed [ACC_W-1:0] rsp_y_accel,
   input  logic signed [ACC_W-1:0] rsp_z_accel,
   input  logic [ACC_W-1:0]        rsp_magnitude,
   input  logic signed [ANG_W-1:0] rsp_angle_xy,
   input  logic signed [ANG_W-1:0] rsp_angle_xz,
   input  logic signed [ANG_W-1:0] rsp_angle_yz,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
      logic [ACC_W-1:0]        mag;
      logic signed [ANG_W-1:0] a_xy;
      logic signed [ANG_W-1:0] a_xz;
      logic signed [ANG_W-1:0] a_yz;
   } tilt_result_type;

   localparam int ROT_STEPS = CORDIC_STEPS_DEF;
   localparam longint HALF_PI = 102944;
   localparam longint PI_LIM  = 25736;
   localparam longint ARCTAN [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
      512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

   logic [OFF_W-1:0]         off_x, off_y, off_z;
   logic signed [GAIN_W-1:0] gain_x, gain_y, gain_z;
   tilt_result_type          expected_tilt [$];

   function automatic longint to_g(logic [ADC_BITS_DEF-1:0] raw, logic [OFF_W-1:0] off,
                                   logic signed [GAIN_W-1:0] g);
      longint d;
      longint p;
      d = 2 * longint'(raw) - longint'(off);
      p = (d * longint'(g)) >>> 16;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return p;
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   // Vectoring rotation; a negative denominator is first turned by a quarter turn.
   function automatic longint tilt_angle(longint num, longint den);
      longint cx, cy, acc, t, xs, ys;
      if (num == 0 && den == 0) return 0;
      cx = den * 256;
      cy = num * 256;
      acc = 0;
      if (cx < 0) begin
         if (cy >= 0) begin
            t = cy; cy = -cx; cx = t; acc = HALF_PI;
         end else begin
            t = -cy; cy = cx; cx = t; acc = -HALF_PI;
         end
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy > 0) begin
            cx += ys; cy -= xs; acc += (i < 17) ? ARCTAN[i] : 0;
         end else begin
            cx -= ys; cy += xs; acc -= (i < 17) ? ARCTAN[i] : 0;
         end
      end
      acc = (acc + 4) >>> 3;
      if (acc > PI_LIM) acc = PI_LIM;
      if (acc < -PI_LIM) acc = -PI_LIM;
      return acc;
   endfunction

   function automatic tilt_result_type predict_tilt(logic [ADC_BITS_DEF-1:0] rx,
                                                    logic [ADC_BITS_DEF-1:0] ry,
                                                    logic [ADC_BITS_DEF-1:0] rz);
      tilt_result_type r;
      longint gx, gy, gz, m;
      gx = to_g(rx, off_x, gain_x);
      gy = to_g(ry, off_y, gain_y);
      gz = to_g(rz, off_z, gain_z);
      m = root_floor(longint'(gx * gx + gy * gy + gz * gz));
      if (m > 65535) m = 65535;
      r.x = gx[15:0];
      r.y = gy[15:0];
      r.z = gz[15:0];
      r.mag = m[15:0];
      r.a_xy = 16'(tilt_angle(gy, gx));
      r.a_xz = 16'(tilt_angle(gz, gx));
      r.a_yz = 16'(tilt_angle(gz, gy));
      return r;
   endfunction

   task automatic compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
         fail_count++;
      end
   endtask

   initial fail_count = 0;
   assign pending = expected_tilt.size();

   always @(posedge clock) begin
      tilt_result_type e;
      if (reset) begin
         off_x <= X_OFF_RST; off_y <= Y_OFF_RST; off_z <= Z_OFF_RST;
         gain_x <= X_GAIN_RST; gain_y <= Y_GAIN_RST; gain_z <= Z_GAIN_RST;
         expected_tilt.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_X_OFF:  off_x <= csr_data[OFF_W-1:0];
               REG_Y_OFF:  off_y <= csr_data[OFF_W-1:0];
               REG_Z_OFF:  off_z <= csr_data[OFF_W-1:0];
               REG_X_GAIN: gain_x <= csr_data;
               REG_Y_GAIN: gain_y <= csr_data;
               REG_Z_GAIN: gain_z <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_tilt.push_back(predict_tilt(req_x_raw, req_y_raw, req_z_raw));
         if (rsp_valid && rsp_ready) begin
            if (expected_tilt.size() == 0) begin
               $display("%0t: response transfer with nothing expected", $time);
               fail_count++;
            end else begin
               e = expected_tilt.pop_front();
               compare_field("x_accel", e.x, rsp_x_accel);
               compare_field("y_accel", e.y, rsp_y_accel);
               compare_field("z_accel", e.z, rsp_z_accel);
               compare_field("magnitude", e.mag, rsp_magnitude);
               compare_field("angle_xy", e.a_xy, rsp_angle_xy);
               compare_field("angle_xz", e.a_xz, rsp_angle_xz);
               compare_field("angle_yz", e.a_yz, rsp_angle_yz);
            end
         end
      end
   end

endmodule

// ===== dv/accel_calibrate_tilt_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// accel_calibrate_tilt_top_test
// Drives sample triples and register writes into the tilt block with random
// gaps and response stalls, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module accel_calibrate_tilt_top_test import acal_pkg::*; ;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 30;

   // An index past the register list; writes to it are dropped.
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [ADC_BITS_DEF-1:0] req_x_raw = '0, req_y_raw = '0, req_z_raw = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [ACC_W-1:0] rsp_x_accel, rsp_y_accel, rsp_z_accel;
   logic [ACC_W-1:0]        rsp_magnitude;
   logic signed [ANG_W-1:0] rsp_angle_xy, rsp_angle_xz, rsp_angle_yz;
   int                      fail_count, pending;
   logic                    req_took = 1'b0;
   logic                    steady = 1'b0;
   int                      stall_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   accel_calibrate_tilt_top dut (.*);
   accel_calibrate_tilt_checker checker_i (.*);

   always @(posedge clock) req_took <= req_valid && req_ready;

   always @(negedge clock)
      rsp_ready = steady || ($urandom_range(99) >= 30);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[accel_calibrate_tilt_top] ERROR");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_calibration(int ox, int oy, int oz, int gx, int gy, int gz);
      write_reg(REG_X_OFF, CSR_DATA_W'(ox));
      write_reg(REG_Y_OFF, CSR_DATA_W'(oy));
      write_reg(REG_Z_OFF, CSR_DATA_W'(oz));
      write_reg(REG_X_GAIN, CSR_DATA_W'(gx));
      write_reg(REG_Y_GAIN, CSR_DATA_W'(gy));
      write_reg(REG_Z_GAIN, CSR_DATA_W'(gz));
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_sample(int rx, int ry, int rz);
      while (!steady && $urandom_range(99) < 30) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_x_raw = rx[ADC_BITS_DEF-1:0];
      req_y_raw = ry[ADC_BITS_DEF-1:0];
      req_z_raw = rz[ADC_BITS_DEF-1:0];
      do begin
         @(posedge clock);
         @(negedge clock);
      end while (!req_took);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic int pick_gain();
      case ($urandom_range(9))
         0: return int'($urandom_range(33554431)) - 16777216;
         1: return int'($urandom_range(40000)) - 20000;
         default: return int'($urandom_range(3000000)) - 1500000;
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset calibration: extremes of the readings and an exact X zero.
      send_sample(0, 0, 0);
      send_sample(1023, 1023, 1023);
      send_sample(518, 0, 1023);
      send_sample(518, 1023, 0);
      send_sample(1023, 0, 512);
      send_sample(0, 1023, 507);
      send_sample(682, 341, 853);
      drain();

      // Zero gains give all-zero operands to the angles.
      set_calibration(0, 0, 0, 0, 0, 0);
      write_reg(REG_NONE, '1);
      send_sample(0, 0, 0);
      send_sample(1023, 1023, 1023);
      drain();

      // Largest gains saturate every axis whose offset difference is large.
      set_calibration(0, 2046, 1023, 16777215, -16777216, 16777215);
      send_sample(1023, 0, 1023);
      send_sample(0, 1023, 0);
      send_sample(511, 1023, 512);
      drain();

      // Mostly negative X with zero or small Y: angles at and near the half-turn clamp.
      set_calibration(2046, 1024, 1024, 65536, 65536, 65536);
      send_sample(0, 512, 512);
      send_sample(1, 512, 1023);
      send_sample(0, 513, 511);
      send_sample(1023, 512, 0);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 0)
            set_calibration(1036, 1031, 1014, -1315860, -1284380, -1383689);
         else
            set_calibration($urandom_range(2046), $urandom_range(2046), $urandom_range(2046),
                            pick_gain(), pick_gain(), pick_gain());
         for (int n = 0; n < 80; n++) begin
            steady = (phase == 2 && n >= 10 && n < 60);
            send_sample($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
         end
         steady = 1'b0;
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("[accel_calibrate_tilt_top] OK");
      else
         $display("[accel_calibrate_tilt_top] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/acal_pkg.sv
hw/rtl/acal_front.sv
hw/rtl/acal_queue.sv
hw/rtl/acal_back.sv
hw/rtl/accel_calibrate_tilt_top.sv
hw/rtl/acal_check.sv
dv/accel_calibrate_tilt_checker.sv
dv/accel_calibrate_tilt_top_test.sv
